// File: sv/trpd_pkg.sv
// Shared types and constants for the tag reply pulse decoder.
// Holds result event codes, register indexes and the pulse window compare.
// No dependencies.
`default_nettype none

package trpd_pkg;

  // Result event codes
  typedef enum logic [2:0] {
    EvProgress = 3'd0,
    EvPreamble = 3'd1,
    EvError    = 3'd2,
    EvHandle   = 3'd3,
    EvByte     = 3'd4
  } event_e;

  // Configuration register indexes
  localparam logic [1:0] RegShortLen = 2'd0;
  localparam logic [1:0] RegLongLen  = 2'd1;
  localparam logic [1:0] RegTolerance = 2'd2;

  // Register reset values
  localparam logic [15:0] ShortLenReset  = 16'd100;
  localparam logic [15:0] LongLenReset   = 16'd200;
  localparam logic [15:0] ToleranceReset = 16'd30;

  // Preamble: short, short, long, short, short+long, long
  localparam logic [2:0] PreamblePulses = 3'd6;
  localparam logic [2:0] EpcTopBit      = 3'd7;

  // Strict window test: nom - tol < p < nom + tol, evaluated without wrap.
  function automatic logic near_len(logic [15:0] p, logic [16:0] nom, logic [15:0] tol);
    logic [17:0] hi;
    logic [17:0] p_hi;
    hi   = {1'b0, nom} + {2'b00, tol};
    p_hi = {2'b00, p} + {2'b00, tol};
    return ({2'b00, p} < hi) && (p_hi > {1'b0, nom});
  endfunction

endpackage

`default_nettype wire

// File: sv/tag_reply_pulse_decoder.sv
// Top level of the tag reply pulse decoder.
// Depends on trpd_pkg for event codes, register indexes and the window compare.
`default_nettype none

// The decoder takes one measured tag pulse length per transfer and returns
// exactly one result per pulse. It first matches the six-pulse preamble
// (short, short, long, short, short+long, long); a pulse matches a nominal
// length when it lies strictly within plus or minus the tolerance. After the
// preamble, two short pulses decode as 0 and one long pulse as 1. In handle
// mode HANDLE_BITS bits are gathered MSB first and reported as event 3, after
// which the block expects an EPC reply behind a fresh preamble; in EPC mode
// bits are packed MSB first into bytes, each reported as event 4, with last_o
// set on byte EPC_BYTES. Any mismatch reports event 2 and restarts preamble
// tracking (a payload mismatch also drops back to handle mode).
// Throughput is one pulse per clock cycle while results are taken: a pulse
// is held in an input register, and the whole decode step (three window
// compares and the state update) is combinational from there into the result
// register, so a pulse passes the input and result registers in that order.
// While a result waits, the input register can still take one more pulse;
// after that in_ready_o stays low until the result is taken.
// Configuration registers short_len, long_len and tolerance are written
// through cfg_we_i/cfg_index_i/cfg_wdata_i; the user must do so only while the
// decoder is idle, as the block does not enforce it. Other indexes are ignored.
module tag_reply_pulse_decoder #(
  parameter int unsigned HANDLE_BITS = 16,
  parameter int unsigned EPC_BYTES   = 14
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  // pulse input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] pulse_length_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       event_res_o,
  output logic [15:0]      data_o,
  output logic             last_o,
  output logic             mode_o
);

  // Mask of the valid handle bits, derived at elaboration.
  localparam logic [15:0] HandleMask = 16'((17'd1 << HANDLE_BITS) - 17'd1);
  localparam logic [4:0]  HandleCnt  = 5'(HANDLE_BITS);
  localparam logic [4:0]  EpcCnt     = 5'(EPC_BYTES);

  // Configuration registers
  logic [15:0] short_len_q, long_len_q, tolerance_q;

  // Input stage
  logic        in_v_q;
  logic [15:0] pulse_q;

  // Result stage
  logic        out_v_q;
  logic [2:0]  event_q;
  logic [15:0] data_q;
  logic        last_q;
  logic        mode_q;

  // Decoder state
  logic [2:0]  pre_idx_q, pre_idx_d;
  logic        half_zero_q, half_zero_d;
  logic        reply_mode_q, reply_mode_d;
  logic [4:0]  hbit_cnt_q, hbit_cnt_d;
  logic [15:0] hshift_q, hshift_d;
  logic [2:0]  ebit_idx_q, ebit_idx_d;
  logic [4:0]  ebyte_cnt_q, ebyte_cnt_d;
  logic [7:0]  eaccum_q, eaccum_d;

  // Step results
  trpd_pkg::event_e ev_d;
  logic [15:0]      data_d;
  logic             last_d;

  logic advance;   // result stage can take a new result
  logic step;      // the held pulse is decoded this cycle

  assign advance    = !out_v_q || out_ready_i;
  assign step       = in_v_q && advance;
  assign in_ready_o = !in_v_q || advance;

  // Configuration writes; unknown indexes drop silently.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_len_q <= trpd_pkg::ShortLenReset;
      long_len_q  <= trpd_pkg::LongLenReset;
      tolerance_q <= trpd_pkg::ToleranceReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        trpd_pkg::RegShortLen:  short_len_q <= cfg_wdata_i;
        trpd_pkg::RegLongLen:   long_len_q  <= cfg_wdata_i;
        trpd_pkg::RegTolerance: tolerance_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register: load on every input transfer, hold a pending pulse while
  // the result stage is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pulse_q <= pulse_length_i;
    end
  end

  // Decode step: one pulse against the current tracking state.
  always_comb begin
    logic [16:0] pre_nom;
    logic        pre_hit;
    logic        short_hit;
    logic        long_hit;
    logic        bit_vld;
    logic        bit_val;
    logic [7:0]  accum_or;

    pre_idx_d    = pre_idx_q;
    half_zero_d  = half_zero_q;
    reply_mode_d = reply_mode_q;
    hbit_cnt_d   = hbit_cnt_q;
    hshift_d     = hshift_q;
    ebit_idx_d   = ebit_idx_q;
    ebyte_cnt_d  = ebyte_cnt_q;
    eaccum_d     = eaccum_q;
    ev_d         = trpd_pkg::EvProgress;
    data_d       = '0;
    last_d       = 1'b0;
    bit_vld      = 1'b0;
    bit_val      = 1'b0;

    // Nominal length of the expected preamble pulse
    unique case (pre_idx_q)
      3'd0, 3'd1, 3'd3: pre_nom = {1'b0, short_len_q};
      3'd2:             pre_nom = {1'b0, long_len_q};
      3'd4:             pre_nom = {1'b0, short_len_q} + {1'b0, long_len_q};
      default:          pre_nom = {1'b0, long_len_q};
    endcase

    pre_hit   = trpd_pkg::near_len(pulse_q, pre_nom, tolerance_q);
    short_hit = trpd_pkg::near_len(pulse_q, {1'b0, short_len_q}, tolerance_q);
    long_hit  = trpd_pkg::near_len(pulse_q, {1'b0, long_len_q}, tolerance_q);
    accum_or  = eaccum_q | (8'd1 << ebit_idx_q);

    if (pre_idx_q < trpd_pkg::PreamblePulses) begin
      if (pre_hit) begin
        pre_idx_d = pre_idx_q + 3'd1;
        if (pre_idx_d >= trpd_pkg::PreamblePulses) begin
          ev_d = trpd_pkg::EvPreamble;
          // Clear the collector for the reply part that follows
          if (!reply_mode_q) begin
            hbit_cnt_d = '0;
            hshift_d   = '0;
          end else begin
            ebit_idx_d  = trpd_pkg::EpcTopBit;
            ebyte_cnt_d = '0;
            eaccum_d    = '0;
          end
        end
      end else begin
        ev_d        = trpd_pkg::EvError;
        pre_idx_d   = '0;
        half_zero_d = 1'b0;
      end
    end else begin
      // Short window wins where the windows overlap
      priority if (short_hit) begin
        if (half_zero_q) begin
          half_zero_d = 1'b0;
          bit_vld     = 1'b1;
        end else begin
          half_zero_d = 1'b1;
        end
      end else if (long_hit) begin
        half_zero_d = 1'b0;
        bit_vld     = 1'b1;
        bit_val     = 1'b1;
      end else begin
        ev_d         = trpd_pkg::EvError;
        pre_idx_d    = '0;
        half_zero_d  = 1'b0;
        reply_mode_d = 1'b0;
      end
    end

    if (bit_vld) begin
      if (!reply_mode_q) begin
        hshift_d   = {hshift_q[14:0], bit_val};
        hbit_cnt_d = hbit_cnt_q + 5'd1;
        if (hbit_cnt_d >= HandleCnt) begin
          ev_d         = trpd_pkg::EvHandle;
          data_d       = hshift_d & HandleMask;
          pre_idx_d    = '0;
          half_zero_d  = 1'b0;
          reply_mode_d = 1'b1;
        end
      end else begin
        eaccum_d = bit_val ? accum_or : eaccum_q;
        if (ebit_idx_q == 3'd0) begin
          ev_d        = trpd_pkg::EvByte;
          data_d      = {8'd0, eaccum_d};
          eaccum_d    = '0;
          ebit_idx_d  = trpd_pkg::EpcTopBit;
          ebyte_cnt_d = ebyte_cnt_q + 5'd1;
          if (ebyte_cnt_d >= EpcCnt) begin
            last_d       = 1'b1;
            pre_idx_d    = '0;
            half_zero_d  = 1'b0;
            reply_mode_d = 1'b0;
          end
        end else begin
          ebit_idx_d = ebit_idx_q - 3'd1;
        end
      end
    end
  end

  // Tracking state advances only when a pulse is decoded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_idx_q    <= '0;
      half_zero_q  <= 1'b0;
      reply_mode_q <= 1'b0;
      hbit_cnt_q   <= '0;
      hshift_q     <= '0;
      ebit_idx_q   <= trpd_pkg::EpcTopBit;
      ebyte_cnt_q  <= '0;
      eaccum_q     <= '0;
    end else if (step) begin
      pre_idx_q    <= pre_idx_d;
      half_zero_q  <= half_zero_d;
      reply_mode_q <= reply_mode_d;
      hbit_cnt_q   <= hbit_cnt_d;
      hshift_q     <= hshift_d;
      ebit_idx_q   <= ebit_idx_d;
      ebyte_cnt_q  <= ebyte_cnt_d;
      eaccum_q     <= eaccum_d;
    end
  end

  // Result register: refill whenever the previous result is gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      event_q <= ev_d;
      data_q  <= data_d;
      last_q  <= last_d;
      mode_q  <= reply_mode_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign event_res_o = event_q;
  assign data_o      = data_q;
  assign last_o      = last_q;
  assign mode_o      = mode_q;

endmodule

`default_nettype wire

// File: sv/trpd_checker.sv
// Port-level checker for the tag reply pulse decoder, with its bind.
// Depends on trpd_pkg for event codes.
`default_nettype none

module trpd_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  event_res_o,
  input wire logic [15:0] data_o,
  input wire logic        last_o,
  input wire logic        mode_o
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_res_o)
      && $stable(data_o) && $stable(last_o) && $stable(mode_o))
    else $error("result changed while stalled");

  // The final byte closes the reply and drops back to handle mode.
  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> event_res_o == 3'(trpd_pkg::EvByte) && !mode_o)
    else $error("last flag outside a final epc byte");

  // A completed handle always moves to epc mode.
  a_handle_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == 3'(trpd_pkg::EvHandle) |-> mode_o)
    else $error("handle complete without epc mode");

  // Data carries a value only on handle and byte events; bytes fit in 8 bits.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != 3'(trpd_pkg::EvHandle)
      && event_res_o != 3'(trpd_pkg::EvByte) |-> data_o == 16'd0)
    else $error("data nonzero on a non-data event");

  a_byte_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == 3'(trpd_pkg::EvByte) |-> data_o[15:8] == 8'd0)
    else $error("epc byte wider than 8 bits");

endmodule

bind tag_reply_pulse_decoder trpd_port_checker u_trpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .event_res_o (event_res_o),
  .data_o      (data_o),
  .last_o      (last_o),
  .mode_o      (mode_o)
);

`default_nettype wire
